### rtl/mpd_pkg.sv
// ============================================================================
// mpd_pkg
// Shared types and codes of the MQTT packet deframer.
// ============================================================================
`default_nettype none

package mpd_pkg;

    localparam int MPD_QUEUE_DEPTH = 2;

    localparam int LEN_W   = 28;
    localparam int TOPIC_W = 16;

    typedef logic [2:0] kind_t;
    typedef logic [2:0] event_t;

    localparam kind_t KIND_HEADER = 3'd0;
    localparam kind_t KIND_LENGTH = 3'd1;
    localparam kind_t KIND_BODY   = 3'd2;
    localparam kind_t KIND_TOPLEN = 3'd3;
    localparam kind_t KIND_TOPIC  = 3'd4;
    localparam kind_t KIND_PKTID  = 3'd5;
    localparam kind_t KIND_MSG    = 3'd6;

    localparam event_t EV_NONE        = 3'd0;
    localparam event_t EV_ACK_OK      = 3'd1;
    localparam event_t EV_ACK_REFUSED = 3'd2;
    localparam event_t EV_PUB_SHORT   = 3'd3;
    localparam event_t EV_LEN_BAD     = 3'd4;

    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    // One classified byte, as handed from the front to the back.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic [3:0]         packet_type;
        kind_t              field_kind;
        logic               last_of_packet;
        logic               len_bad;
        logic               check_end;
        logic [LEN_W-1:0]   remaining_length;
        logic [TOPIC_W-1:0] topic_length;
        logic               connack_ok;
    } mpd_rec_t;

    typedef struct packed {
        logic can_push;
        logic can_pop;
    } mpd_qstat_t;

endpackage

`default_nettype wire

### rtl/mpd_if.sv
// ============================================================================
// mpd_if
// Valid/ready channels of the MQTT packet deframer.
// ============================================================================
`default_nettype none

interface mpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [3:0]  packet_type;
    logic [2:0]  field_kind;
    logic        last_of_packet;
    logic [2:0]  packet_event;
    logic [27:0] remaining_length;
    logic        link_up;

    modport source (output valid, output data_byte, output packet_type, output field_kind,
                    output last_of_packet, output packet_event, output remaining_length,
                    output link_up, input ready);
    modport sink   (input valid, input data_byte, input packet_type, input field_kind,
                    input last_of_packet, input packet_event, input remaining_length,
                    input link_up, output ready);
endinterface

`default_nettype wire

### rtl/mpd_front.sv
// ============================================================================
// mpd_front
// Accepts bytes, tracks the packet framing and labels each byte.
// ============================================================================
`default_nettype none

module mpd_front
    import mpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpd_in_if.sink    rx,
    input  wire logic push_ready,
    output logic      push_valid,
    output mpd_rec_t  push_rec
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic [1:0]         phase_reg,   phase_next;
    logic [3:0]         type_reg,    type_next;
    logic               qos_reg,     qos_next;
    logic [LEN_W-1:0]   accum_reg,   accum_next;
    logic [1:0]         lcount_reg,  lcount_next;
    logic [LEN_W-1:0]   pos_reg,     pos_next;
    logic [TOPIC_W-1:0] topic_reg,   topic_next;
    logic               ackok_reg,   ackok_next;

    logic             accept;
    logic [LEN_W-1:0] len_part;
    logic [LEN_W-1:0] topic_end;
    logic [LEN_W-1:0] pktid_end;
    logic [LEN_W:0]   pos_inc;
    kind_t            kind;
    logic             last;
    logic             len_bad;
    logic             check_end;

    assign rx.ready = push_ready;
    assign accept   = rx.valid & push_ready;

    always_comb
    begin
        unique case (lcount_reg)
            2'd0: len_part = {21'd0, rx.rx_byte[6:0]};
            2'd1: len_part = {14'd0, rx.rx_byte[6:0], 7'd0};
            2'd2: len_part = {7'd0, rx.rx_byte[6:0], 14'd0};
            default: len_part = {rx.rx_byte[6:0], 21'd0};
        endcase
    end

    assign topic_end = {{(LEN_W-TOPIC_W-1){1'b0}}, {1'b0, topic_reg} + 17'd2};
    assign pktid_end = {{(LEN_W-TOPIC_W-1){1'b0}}, {1'b0, topic_reg} + 17'd4};
    assign pos_inc   = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        qos_next    = qos_reg;
        accum_next  = accum_reg;
        lcount_next = lcount_reg;
        pos_next    = pos_reg;
        topic_next  = topic_reg;
        ackok_next  = ackok_reg;
        kind        = KIND_HEADER;
        last        = 1'b0;
        len_bad     = 1'b0;
        check_end   = 1'b0;
        priority if (phase_reg == PH_LENGTH)
        begin
            kind       = KIND_LENGTH;
            accum_next = accum_reg | len_part;
            if (rx.rx_byte[7])
            begin
                if (lcount_reg == 2'd3)
                begin
                    len_bad    = 1'b1;
                    last       = 1'b1;
                    phase_next = PH_HEADER;
                end
                else
                begin
                    lcount_next = lcount_reg + 2'd1;
                end
            end
            else if (accum_next == '0)
            begin
                last       = 1'b1;
                check_end  = 1'b1;
                phase_next = PH_HEADER;
            end
            else
            begin
                phase_next = PH_BODY;
            end
        end
        else if (phase_reg == PH_BODY)
        begin
            if (type_reg == TYPE_PUBLISH)
            begin
                priority if (pos_reg < LEN_W'(2))
                begin
                    kind = KIND_TOPLEN;
                    if (pos_reg == '0)
                        topic_next = {rx.rx_byte, 8'd0};
                    else
                        topic_next = {topic_reg[15:8], rx.rx_byte};
                end
                else if (pos_reg < topic_end)
                    kind = KIND_TOPIC;
                else if (qos_reg && (pos_reg < pktid_end))
                    kind = KIND_PKTID;
                else
                    kind = KIND_MSG;
            end
            else
            begin
                kind = KIND_BODY;
                if (pos_reg == LEN_W'(1))
                    ackok_next = (rx.rx_byte == 8'd0);
            end
            if (pos_inc >= {1'b0, accum_reg})
            begin
                last       = 1'b1;
                check_end  = 1'b1;
                phase_next = PH_HEADER;
            end
            else
            begin
                pos_next = pos_inc[LEN_W-1:0];
            end
        end
        else
        begin
            // Header byte; also covers the unused phase code.
            kind        = KIND_HEADER;
            type_next   = rx.rx_byte[7:4];
            qos_next    = |rx.rx_byte[2:1];
            accum_next  = '0;
            lcount_next = '0;
            pos_next    = '0;
            topic_next  = '0;
            ackok_next  = 1'b0;
            phase_next  = PH_LENGTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            type_reg   <= '0;
            qos_reg    <= 1'b0;
            accum_reg  <= '0;
            lcount_reg <= '0;
            pos_reg    <= '0;
            topic_reg  <= '0;
            ackok_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            qos_reg    <= qos_next;
            accum_reg  <= accum_next;
            lcount_reg <= lcount_next;
            pos_reg    <= pos_next;
            topic_reg  <= topic_next;
            ackok_reg  <= ackok_next;
        end
    end

    assign push_valid                = accept;
    assign push_rec.data_byte        = rx.rx_byte;
    assign push_rec.packet_type      = type_next;
    assign push_rec.field_kind       = kind;
    assign push_rec.last_of_packet   = last;
    assign push_rec.len_bad          = len_bad;
    assign push_rec.check_end        = check_end;
    assign push_rec.remaining_length = accum_next;
    assign push_rec.topic_length     = topic_next;
    assign push_rec.connack_ok       = ackok_next;

endmodule

`default_nettype wire

### rtl/mpd_queue.sv
// ============================================================================
// mpd_queue
// Short FIFO of classified bytes between the front and the back.
// ============================================================================
`default_nettype none

module mpd_queue
    import mpd_pkg::*;
#(
    parameter int DEPTH = MPD_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire mpd_rec_t push_rec,
    input  wire logic     pop,
    output mpd_rec_t      pop_rec,
    output mpd_qstat_t    stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mpd_rec_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign stat.can_push = (count_reg != CW'(DEPTH));
    assign stat.can_pop  = (count_reg != '0);
    assign pop_rec       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

### rtl/mpd_back.sv
// ============================================================================
// mpd_back
// Runs the end-of-packet checks, keeps the link flag and drives the output.
// ============================================================================
`default_nettype none

module mpd_back
    import mpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     rec_valid,
    input  wire mpd_rec_t rec,
    output logic          rec_take,
    mpd_out_if.source     tx
);

    logic             valid_reg;
    logic             link_reg,  link_next;
    logic [7:0]       byte_reg;
    logic [3:0]       type_reg;
    kind_t            kind_reg;
    logic             last_reg;
    event_t           event_reg, event_next;
    logic [LEN_W-1:0] len_reg;

    logic [LEN_W-1:0] topic_end;

    assign rec_take  = rec_valid && (!valid_reg || tx.ready);
    assign topic_end = {{(LEN_W-TOPIC_W-1){1'b0}}, {1'b0, rec.topic_length} + 17'd2};

    always_comb
    begin
        event_next = EV_NONE;
        link_next  = link_reg;
        priority if (rec.len_bad)
            event_next = EV_LEN_BAD;
        else if (rec.check_end && (rec.packet_type == TYPE_CONNACK))
        begin
            if ((rec.remaining_length >= LEN_W'(2)) && rec.connack_ok)
            begin
                event_next = EV_ACK_OK;
                link_next  = 1'b1;
            end
            else
                event_next = EV_ACK_REFUSED;
        end
        else if (rec.check_end && (rec.packet_type == TYPE_PUBLISH))
        begin
            if ((rec.remaining_length < LEN_W'(2)) || (rec.remaining_length < topic_end))
                event_next = EV_PUB_SHORT;
        end
        else
            event_next = EV_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            link_reg  <= 1'b0;
        end
        else
        begin
            if (rec_take)
            begin
                valid_reg <= 1'b1;
                link_reg  <= link_next;
            end
            else if (tx.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            byte_reg  <= rec.data_byte;
            type_reg  <= rec.packet_type;
            kind_reg  <= rec.field_kind;
            last_reg  <= rec.last_of_packet;
            event_reg <= event_next;
            len_reg   <= rec.remaining_length;
        end
    end

    assign tx.valid            = valid_reg;
    assign tx.data_byte        = byte_reg;
    assign tx.packet_type      = type_reg;
    assign tx.field_kind       = kind_reg;
    assign tx.last_of_packet   = last_reg;
    assign tx.packet_event     = event_reg;
    assign tx.remaining_length = len_reg;
    assign tx.link_up          = link_reg;

endmodule

`default_nettype wire

### rtl/mqtt_packet_deframer_top.sv
// ============================================================================
// mqtt_packet_deframer_top
// MQTT 3.1.1 fixed-header deframer: labels each received byte with its field.
// ============================================================================
//
//   channel  dir  handshake    payload
//   rx_ch    in   valid/ready  rx_byte
//   tx_ch    out  valid/ready  data_byte, packet_type, field_kind, last_of_packet,
//                              packet_event, remaining_length, link_up
//
// One byte per cycle sustained while tx_ch keeps taking results; an accepted
// byte is written to the queue, then to the output register, before tx_ch shows it.
// Reset (rst_n low, asynchronous) puts the parser at "expecting header" with
// link_up low and empties the queue; no clearing pass is needed.
// A stall on tx_ch fills the queue first; rx_ch.ready drops only when the
// queue is full, so QUEUE_DEPTH bytes plus the output register absorb it.
// ============================================================================
`default_nettype none

module mqtt_packet_deframer_top
    import mpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = MPD_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpd_in_if.sink    rx_ch,
    mpd_out_if.source tx_ch
);

    mpd_qstat_t q_stat;
    mpd_rec_t   push_rec;
    mpd_rec_t   pop_rec;
    logic       push_valid;
    logic       pop_take;

    // Front: framing state, byte labels; writes one record per accepted byte.
    mpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .push_ready (q_stat.can_push),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    // Decouple so an output stall does not immediately hold the input.
    mpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_rec (push_rec),
        .pop      (pop_take),
        .pop_rec  (pop_rec),
        .stat     (q_stat)
    );

    // Back: packet-end events, link flag, output register.
    mpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_stat.can_pop),
        .rec       (pop_rec),
        .rec_take  (pop_take),
        .tx        (tx_ch)
    );

endmodule

`default_nettype wire

### tb/tb_mqtt_packet_deframer_top.sv
// ============================================================================
// tb_mqtt_packet_deframer_top
// Self-checking bench for the MQTT fixed-header deframer.
//
// Bytes go in on rx_ch one request at a time. On every accepted request a
// local model of the parser labels the byte and queues the result it should
// give. Every result taken from tx_ch is checked field by field against the
// oldest queued label. Directed frames come first: CONNACK accepted and
// refused, a PUBLISH with packet id, a short PUBLISH, an overlong length and
// an empty body with a padded 4-byte length. Then come random framed traffic
// and broken frames, and last a frame with the largest remaining length.
// Both sides idle at random, with bursts where neither does.
// ============================================================================
`default_nettype none

module tb_mqtt_packet_deframer_top;
    import mpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Parser phase of the local model.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } parse_phase_t;

    // One labelled byte, as the block should hand it out.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic [3:0]       packet_type;
        kind_t            field_kind;
        logic             last_of_packet;
        event_t           packet_event;
        logic [LEN_W-1:0] remaining_length;
        logic             link_up;
    } labelled_byte_t;

    localparam int unsigned RANDOM_BYTES = 960;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mpd_in_if  rx_ch ();
    mpd_out_if tx_ch ();

    mqtt_packet_deframer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx_ch (rx_ch),
        .tx_ch (tx_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local model of the parser state
    // ------------------------------------------------------------------------
    parse_phase_t       pr_phase  = PH_HEADER;
    logic [3:0]         pr_type   = '0;
    logic               pr_qos    = 1'b0;
    logic [LEN_W-1:0]   pr_len    = '0;
    logic [1:0]         pr_len_cnt = '0;
    logic [LEN_W-1:0]   pr_pos    = '0;
    logic [TOPIC_W-1:0] pr_topic  = '0;
    logic               pr_ack_ok = 1'b0;
    logic               pr_link   = 1'b0;

    labelled_byte_t pending_labels[$];
    logic [7:0]     frame[$];

    // High: neither side idles, so requests go back to back.
    logic no_idle = 1'b0;

    int unsigned mismatches     = 0;
    int unsigned requests_sent  = 0;
    int unsigned packets_closed = 0;
    int unsigned events_seen[5] = '{default: 0};

    // Run the end-of-packet checks; latch link_up on an accepted CONNACK.
    function automatic event_t close_packet();
        if (pr_type == TYPE_CONNACK)
        begin
            if (pr_len >= 2 && pr_ack_ok)
            begin
                pr_link = 1'b1;
                return EV_ACK_OK;
            end
            return EV_ACK_REFUSED;
        end
        // A length below 2 is also below 2 plus the topic length.
        if (pr_type == TYPE_PUBLISH && 32'(pr_len) < 32'(pr_topic) + 32'd2)
            return EV_PUB_SHORT;
        return EV_NONE;
    endfunction

    // Advance the model by one byte and return the label it should get.
    function automatic labelled_byte_t label_byte(input logic [7:0] b);
        labelled_byte_t r;
        logic [31:0]    pos;
        logic [31:0]    topic_end;
        r.field_kind     = KIND_HEADER;
        r.last_of_packet = 1'b0;
        r.packet_event   = EV_NONE;
        case (pr_phase)
            PH_LENGTH:
            begin
                r.field_kind = KIND_LENGTH;
                pr_len = pr_len | (LEN_W'(b[6:0]) << (7 * pr_len_cnt));
                if (b[7])
                begin
                    if (pr_len_cnt == 2'd3)
                    begin
                        // Overlong length: flag it and resync on the next byte.
                        r.packet_event   = EV_LEN_BAD;
                        r.last_of_packet = 1'b1;
                        pr_phase         = PH_HEADER;
                    end
                    else
                        pr_len_cnt = pr_len_cnt + 2'd1;
                end
                else if (pr_len == '0)
                begin
                    // Empty body: the last length byte closes the packet.
                    r.last_of_packet = 1'b1;
                    r.packet_event   = close_packet();
                    pr_phase         = PH_HEADER;
                end
                else
                    pr_phase = PH_BODY;
            end
            PH_BODY:
            begin
                pos       = 32'(pr_pos);
                topic_end = 32'(pr_topic) + 32'd2;
                if (pr_type == TYPE_PUBLISH)
                begin
                    if (pos < 2)
                    begin
                        r.field_kind = KIND_TOPLEN;
                        if (pos == 0)
                            pr_topic = {b, 8'h00};
                        else
                            pr_topic[7:0] = b;
                    end
                    else if (pos < topic_end)
                        r.field_kind = KIND_TOPIC;
                    else if (pr_qos && pos < topic_end + 32'd2)
                        r.field_kind = KIND_PKTID;
                    else
                        r.field_kind = KIND_MSG;
                end
                else
                begin
                    r.field_kind = KIND_BODY;
                    if (pos == 1)
                        pr_ack_ok = (b == 8'h00);
                end
                if (pos + 32'd1 >= 32'(pr_len))
                begin
                    r.last_of_packet = 1'b1;
                    r.packet_event   = close_packet();
                    pr_phase         = PH_HEADER;
                end
                else
                    pr_pos = pr_pos + 1'b1;
            end
            default:
            begin
                // Header byte; an unknown phase is taken as header as well.
                pr_type    = b[7:4];
                pr_qos     = (b[2:1] != 2'b00);
                pr_len     = '0;
                pr_len_cnt = '0;
                pr_pos     = '0;
                pr_topic   = '0;
                pr_ack_ok  = 1'b0;
                pr_phase   = PH_LENGTH;
            end
        endcase
        r.data_byte        = b;
        r.packet_type      = pr_type;
        r.remaining_length = pr_len;
        r.link_up          = pr_link;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: label every accepted request, check every accepted result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rx_ch.valid && rx_ch.ready)
            pending_labels.push_back(label_byte(rx_ch.rx_byte));
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        labelled_byte_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (pending_labels.size() == 0)
            begin
                $error("result with no request waiting: data_byte %0d", tx_ch.data_byte);
                mismatches++;
            end
            else
            begin
                want = pending_labels.pop_front();
                compare_field("data_byte", 32'(want.data_byte), 32'(tx_ch.data_byte));
                compare_field("packet_type", 32'(want.packet_type), 32'(tx_ch.packet_type));
                compare_field("field_kind", 32'(want.field_kind), 32'(tx_ch.field_kind));
                compare_field("last_of_packet", 32'(want.last_of_packet),
                              32'(tx_ch.last_of_packet));
                compare_field("packet_event", 32'(want.packet_event),
                              32'(tx_ch.packet_event));
                compare_field("remaining_length", 32'(want.remaining_length),
                              32'(tx_ch.remaining_length));
                compare_field("link_up", 32'(want.link_up), 32'(tx_ch.link_up));
                if (want.last_of_packet)
                    packets_closed++;
                if (want.packet_event <= EV_LEN_BAD)
                    events_seen[want.packet_event]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: draw a stall for every result, hold ready low through it
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        tx_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            // Keep ready high across back-to-back results: one assignment per step.
            tx_ch.ready <= 1'b1;
            do @(posedge clk); while (!tx_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Drive one byte after a random gap; return at the edge that takes it.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            // Drop valid and put junk on the bus while idle.
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        do @(posedge clk); while (!rx_ch.ready);
        requests_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
    endtask

    // Hold the request side until every queued label has been matched.
    task automatic wait_drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_labels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Append a variable-byte length, padded with zero groups to min_bytes.
    task automatic push_length(input int unsigned len, input int unsigned min_bytes);
        int unsigned rest;
        int unsigned n;
        logic [7:0]  b;
        rest = len;
        n    = 0;
        do
        begin
            b    = {1'b0, 7'(rest)};
            rest = rest >> 7;
            n++;
            if (rest != 0 || n < min_bytes)
                b[7] = 1'b1;
            frame.push_back(b);
        end
        while (rest != 0 || n < min_bytes);
    endtask

    // Build one frame: mostly well-formed PUBLISH/CONNACK/other traffic with
    // random content, with short PUBLISHes, odd CONNACKs and overlong lengths mixed in.
    task automatic build_random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned t;
        int unsigned m;
        int unsigned min_len_bytes;
        logic [3:0]  flags;
        logic [15:0] topic_field;
        logic        qos;
        frame.delete();
        pick          = $urandom_range(0, 99);
        flags         = 4'($urandom);
        min_len_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 1;
        if (pick < 40)
        begin
            qos = (flags[2:1] != 2'b00);
            t   = $urandom_range(0, 6);
            m   = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
                m = m + $urandom_range(100, 300);
            len         = 2 + t + (qos ? 2 : 0) + m;
            topic_field = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(t);
            // Cut some frames short of their topic.
            if ($urandom_range(0, 6) == 0)
                len = $urandom_range(0, len - 1);
            frame.push_back({TYPE_PUBLISH, flags});
            push_length(len, min_len_bytes);
            for (int unsigned i = 0; i < len; i++)
                frame.push_back(i == 0 ? topic_field[15:8] :
                                i == 1 ? topic_field[7:0] : 8'($urandom));
        end
        else if (pick < 60)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 2;
            frame.push_back({TYPE_CONNACK, flags});
            push_length(len, min_len_bytes);
            for (int unsigned i = 0; i < len; i++)
                frame.push_back((i == 1 && $urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom));
        end
        else if (pick < 70)
        begin
            // Four continuation bytes: the length runs past its limit.
            frame.push_back(8'($urandom));
            repeat (4) frame.push_back({1'b1, 7'($urandom)});
        end
        else
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 300)
                                                : $urandom_range(0, 10);
            frame.push_back(8'($urandom));
            push_length(len, min_len_bytes);
            for (int unsigned i = 0; i < len; i++)
                frame.push_back(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_frames();
        // CONNACK refused: return code 0xFF; link stays down.
        frame = '{8'h20, 8'h02, 8'h00, 8'hFF};
        send_frame();
        // CONNACK accepted: link comes up.
        frame = '{8'h20, 8'h02, 8'h00, 8'h00};
        send_frame();
        // PUBLISH QoS 1, empty topic: topic length, packet id, one message byte.
        frame = '{8'h32, 8'h05, 8'h00, 8'h00, 8'h12, 8'h34, 8'h55};
        send_frame();
        // PUBLISH with a length below 2.
        frame = '{8'h30, 8'h01, 8'h00};
        send_frame();
        // Overlong length, then resync on the following header.
        frame = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        // Empty body carried by a padded 4-byte length.
        frame = '{8'h90, 8'h80, 8'h80, 8'h80, 8'h00};
        send_frame();
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        stop_at = requests_sent + RANDOM_BYTES;
        while (requests_sent < stop_at)
        begin
            // Run about one frame in five with no idling on either side.
            no_idle = ($urandom_range(0, 4) == 0);
            build_random_frame();
            send_frame();
            if ($urandom_range(0, 49) == 0)
                wait_drain();
        end
        no_idle = 1'b0;
        wait_drain();
    endtask

    task automatic test_max_length();
        // Largest remaining length, sent back to back; the body stays open.
        no_idle = 1'b1;
        frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'hA5, 8'h5A};
        send_frame();
        no_idle = 1'b0;
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_traffic();
        test_max_length();

        repeat (10) @(posedge clk);
        if (pending_labels.size() != 0)
        begin
            $error("%0d results never arrived", pending_labels.size());
            mismatches++;
        end

        $display("covered %0d requests over %0d closed packets", requests_sent,
                 packets_closed);
        $display("events: connack ok %0d, refused %0d, short publish %0d, bad length %0d",
                 events_seen[EV_ACK_OK], events_seen[EV_ACK_REFUSED],
                 events_seen[EV_PUB_SHORT], events_seen[EV_LEN_BAD]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
